>>> src/mss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the maximum segment sum tree.
// ----------------------------------------------------------------------------
package mss_pkg;

    localparam int LEAF_BITS      = 10;
    localparam int LEAVES         = 2 ** LEAF_BITS;
    localparam int VALUE_BITS     = 32;
    localparam int SUM_BITS       = VALUE_BITS + LEAF_BITS;
    localparam int BEST_BITS      = 41;
    localparam int ADDR_BITS      = LEAF_BITS + 1;
    localparam int DEPTH          = 2 ** ADDR_BITS;
    localparam int IN_DATA_BITS   = 48;
    localparam int OUT_DATA_BITS  = 48;

    localparam logic [ADDR_BITS-1:0] ROOT_ADDR = ADDR_BITS'(1);

    typedef logic signed [SUM_BITS-1:0] sum_t;
    typedef logic [ADDR_BITS-1:0]       addr_t;

    typedef struct packed {
        sum_t best;
        sum_t suffix;
        sum_t prefix;
        sum_t total;
    } node_t;

    localparam int NODE_BITS = $bits(node_t);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF,
        ST_CLIMB,
        ST_FINISH
    } state_t;

endpackage

>>> src/mss_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_node_ram
// Node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mss_node_ram
(
    input  logic            clk,
    input  logic            we,
    input  mss_pkg::addr_t  waddr,
    input  mss_pkg::node_t  wdata,
    input  mss_pkg::addr_t  raddr,
    output mss_pkg::node_t  rdata
);

    mss_pkg::node_t mem [mss_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> src/mss_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_merge
// Combines two sibling nodes into their parent.
// ----------------------------------------------------------------------------
module mss_merge
(
    input  mss_pkg::node_t left,
    input  mss_pkg::node_t right,
    output mss_pkg::node_t parent
);

    mss_pkg::sum_t pre_cross;
    mss_pkg::sum_t suf_cross;
    mss_pkg::sum_t mid_cross;
    mss_pkg::sum_t side_best;

    always_comb
    begin
        pre_cross = left.total + right.prefix;
        suf_cross = right.total + left.suffix;
        mid_cross = left.suffix + right.prefix;
        side_best = (left.best > right.best) ? left.best : right.best;

        parent.total  = left.total + right.total;
        parent.prefix = (left.prefix > pre_cross) ? left.prefix : pre_cross;
        parent.suffix = (right.suffix > suf_cross) ? right.suffix : suf_cross;
        parent.best   = (side_best > mid_cross) ? side_best : mid_cross;
    end

endmodule

>>> src/max_subarray_segment_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_subarray_segment_tree
// Point-update segment tree reporting the maximum contiguous segment sum.
// ----------------------------------------------------------------------------
// Each item writes one element and walks from its leaf to the root, one tree
// level per cycle through the single read port of the node store, in the steps
// accept, leaf write, 10 merges and finish; the finish step waits for the
// output register when a report is requested. After reset a clearing pass
// zeroes the 2048-entry node store, one entry per cycle, before the first
// item is taken. The reported sum is the root's best segment, floored at 0.
module max_subarray_segment_tree
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // index[9:0], value[41:10], zero pad
    input  logic        s_tuser,    // report

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // best_sum[40:0], zero pad
);

    mss_pkg::state_t state_reg, state_next;
    mss_pkg::addr_t  clr_addr_reg, clr_addr_next;
    mss_pkg::addr_t  node_reg, node_next;
    mss_pkg::node_t  cur_reg, cur_next;
    logic            report_reg, report_next;
    mss_pkg::sum_t   root_best_reg, root_best_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic [mss_pkg::BEST_BITS-1:0] m_best_reg, m_best_next;

    logic            ram_we;
    mss_pkg::addr_t  ram_waddr;
    mss_pkg::node_t  ram_wdata;
    mss_pkg::addr_t  ram_raddr;
    mss_pkg::node_t  ram_rdata;

    mss_pkg::node_t  merge_left;
    mss_pkg::node_t  merge_right;
    mss_pkg::node_t  merged;

    logic [mss_pkg::LEAF_BITS-1:0]  in_index;
    logic signed [mss_pkg::VALUE_BITS-1:0] in_value;
    mss_pkg::sum_t   leaf_sum;
    mss_pkg::addr_t  parent_addr;
    logic [mss_pkg::BEST_BITS-1:0] clamped_best;

    assign in_index    = s_tdata[mss_pkg::LEAF_BITS-1:0];
    assign in_value    = s_tdata[mss_pkg::LEAF_BITS +: mss_pkg::VALUE_BITS];
    assign leaf_sum    = mss_pkg::sum_t'(in_value);
    assign parent_addr = {1'b0, node_reg[mss_pkg::ADDR_BITS-1:1]};
    assign clamped_best = root_best_reg[mss_pkg::SUM_BITS-1] ?
                          '0 : root_best_reg[mss_pkg::BEST_BITS-1:0];

    // current node is a right child when its address is odd
    assign merge_left  = node_reg[0] ? ram_rdata : cur_reg;
    assign merge_right = node_reg[0] ? cur_reg   : ram_rdata;

    mss_node_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mss_merge u_merge
    (
        .left   (merge_left),
        .right  (merge_right),
        .parent (merged)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        report_next    = report_reg;
        root_best_next = root_best_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_best_next    = m_best_reg;
        ram_we         = 1'b0;
        ram_waddr      = node_reg;
        ram_wdata      = cur_reg;
        ram_raddr      = {node_reg[mss_pkg::ADDR_BITS-1:1], ~node_reg[0]};
        s_tready       = 1'b0;

        unique case (state_reg)
            mss_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + mss_pkg::ADDR_BITS'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = mss_pkg::ST_IDLE;
                end
            end
            mss_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    node_next       = {1'b1, in_index};
                    cur_next.total  = leaf_sum;
                    cur_next.prefix = leaf_sum;
                    cur_next.suffix = leaf_sum;
                    cur_next.best   = leaf_sum;
                    report_next     = s_tuser;
                    state_next      = mss_pkg::ST_LEAF;
                end
            end
            mss_pkg::ST_LEAF:
            begin
                ram_we     = 1'b1;
                state_next = mss_pkg::ST_CLIMB;
            end
            mss_pkg::ST_CLIMB:
            begin
                ram_we    = 1'b1;
                ram_waddr = parent_addr;
                ram_wdata = merged;
                ram_raddr = {parent_addr[mss_pkg::ADDR_BITS-1:1], ~parent_addr[0]};
                cur_next  = merged;
                node_next = parent_addr;
                if (parent_addr == mss_pkg::ROOT_ADDR)
                begin
                    root_best_next = merged.best;
                    state_next     = mss_pkg::ST_FINISH;
                end
            end
            mss_pkg::ST_FINISH:
            begin
                if (!report_reg)
                begin
                    state_next = mss_pkg::ST_IDLE;
                end
                else if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_best_next   = clamped_best;
                    state_next    = mss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            root_best_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            root_best_reg <= root_best_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        cur_reg    <= cur_next;
        report_reg <= report_next;
        m_best_reg <= m_best_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(mss_pkg::OUT_DATA_BITS - mss_pkg::BEST_BITS)'(0), m_best_reg};

endmodule
